FILE: design/gars_pkg.sv
// Package for the geometric attitude rate setpoint block.
// Holds sequencer states, op and register codes, fixed constants and the
// control struct of the shared multiply-accumulate unit. No dependencies.
package gars_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEE,
        ST_VWAIT,
        ST_LATCH,
        ST_SCALE,
        ST_SWAIT,
        ST_FIN,
        ST_DIV,
        ST_DONE
    } state_t;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_RATE  = 2'd1;
    localparam logic [1:0] OP_ACCEL = 2'd2;

    localparam logic [7:0] REG_YAW_WEIGHT = 8'd0;
    localparam logic [7:0] REG_ROLL_LIM   = 8'd1;
    localparam logic [7:0] REG_PITCH_LIM  = 8'd2;
    localparam logic [7:0] REG_YAW_LIM    = 8'd3;

    localparam int ACC_W  = 58;
    localparam int MUL_AW = 20;
    localparam int MUL_BW = 21;
    localparam int NUM_W  = 56;
    localparam int DEN_W  = 34;
    localparam int QUO_W  = 32;

    localparam logic [4:0] SH_NONE = 5'd0;
    localparam logic [4:0] SH_FF   = 5'd14;
    localparam logic [4:0] SH_HI   = 5'd17;

    localparam logic [19:0] DT_MIN_US = 20'd100;
    localparam logic [19:0] DT_MAX_US = 20'd100000;
    localparam logic signed [15:0] YAW_NAN = 16'sh8000;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [20:0] K_USEC  = 21'sd1000000;
    localparam logic signed [20:0] K_FIVE  = 21'sd5;
    localparam logic signed [20:0] K_RATE  = 21'sd20480;
    localparam logic [12:0] W_ONE = 13'd4096;

    typedef struct packed {
        logic       en;
        logic       clr;
        logic       neg;
        logic [4:0] sh;
    } mac_ctrl_t;

    function automatic logic [1:0] axis_p(input logic [1:0] ax);
        logic [1:0] r;
        case (ax)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] axis_q(input logic [1:0] ax);
        logic [1:0] r;
        case (ax)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/gars_mac.sv
// Shared multiply-accumulate unit: registered product, then shifted add or
// subtract into a wide accumulator. Uses gars_pkg.
module gars_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gars_pkg::mac_ctrl_t                ctrl,
    input  logic signed [gars_pkg::MUL_AW-1:0] a,
    input  logic signed [gars_pkg::MUL_BW-1:0] b,
    output logic signed [gars_pkg::ACC_W-1:0]  acc
);
    localparam int PW = gars_pkg::MUL_AW + gars_pkg::MUL_BW;

    gars_pkg::mac_ctrl_t              ctrl_reg;
    logic signed [PW-1:0]             prod_reg;
    logic signed [gars_pkg::ACC_W-1:0] acc_reg;
    logic signed [gars_pkg::ACC_W-1:0] acc_next;
    logic signed [gars_pkg::ACC_W-1:0] base;
    logic signed [gars_pkg::ACC_W-1:0] term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        base = ctrl_reg.clr ? '0 : acc_reg;
        term = {{(gars_pkg::ACC_W-PW){prod_reg[PW-1]}}, prod_reg} <<< ctrl_reg.sh;
        acc_next = acc_reg;
        if (ctrl_reg.en)
        begin
            acc_next = ctrl_reg.neg ? base - term : base + term;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: design/gars_div.sv
// Restoring divider, one quotient bit per cycle, for a 32-bit quotient.
// The numerator's top bits must already be below the divisor. Uses gars_pkg.
module gars_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gars_pkg::NUM_W-1:0]    num,
    input  logic [gars_pkg::DEN_W-1:0]    den,
    output logic                          done,
    output logic [gars_pkg::QUO_W-1:0]    quo
);
    localparam int DW = gars_pkg::DEN_W;
    localparam int QW = gars_pkg::QUO_W;

    logic                  busy_reg;
    logic                  done_reg;
    logic [4:0]            cnt_reg;
    logic [DW-1:0]         rem_reg;
    logic [DW-1:0]         den_reg;
    logic [QW-1:0]         nq_reg;
    logic [DW:0]           trial;
    logic                  ge;
    logic [DW:0]           diff;

    always_comb
    begin
        trial = {rem_reg, nq_reg[QW-1]};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(DW-(gars_pkg::NUM_W-QW)){1'b0}}, num[gars_pkg::NUM_W-1:QW]};
            nq_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            nq_reg  <= {nq_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = nq_reg;

endmodule

FILE: design/geometric_attitude_rate_setpoint.sv
// Geometric attitude rate setpoint: top level, sequencer and state.
// Uses gars_pkg, gars_mac and gars_div.
// One item at a time, one shared 20x21 multiplier with a 58-bit accumulator.
// Per axis: six products, 2 or 3 scaling passes and a few control states;
// op 0 with a valid time step adds a pass of the serial divider on each axis.
// op 0 with no usable time step and op 3 go straight to the done state, with
// no products. A result may
// wait in the output register while the next item is taken.
module geometric_attitude_rate_setpoint (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    input  logic signed [15:0] m21,
    input  logic signed [15:0] m22,
    input  logic signed [15:0] yaw_speed,
    input  logic [19:0]        step_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] out_x,
    output logic signed [17:0] out_y,
    output logic signed [17:0] out_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    localparam int AW = gars_pkg::ACC_W;

    gars_pkg::state_t state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic [1:0]  axis_reg, axis_next;

    logic [12:0] yaw_weight_reg;
    logic [15:0] roll_lim_reg, pitch_lim_reg, yaw_lim_reg;

    logic signed [15:0] d_reg [9];
    logic signed [15:0] m_reg [9];
    logic signed [16:0] b_reg [9];
    logic signed [17:0] dbr_reg [3];
    logic signed [17:0] res_reg [3];
    logic               seen_reg;
    logic signed [15:0] yaw_reg;
    logic [1:0]         op_reg;
    logic [16:0]        dt_reg;
    logic signed [36:0] s_reg;
    logic               out_valid_reg;
    logic signed [17:0] out_x_reg, out_y_reg, out_z_reg;

    logic signed [15:0] m_in [9];
    logic accept, dt_ok, load_out, ff_on, div_start, div_done;
    logic [3:0] ia, ib;
    logic [1:0] col_a, col_b;
    logic signed [19:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [20:0] k_sel;
    logic [12:0] w_cl;
    logic signed [36:0] x_val;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] sum2;
    logic [AW-1:0] mag, rnd;
    logic [15:0] lim;
    logic [29:0] q1;
    logic signed [17:0] fin_res, div_res;
    logic [gars_pkg::QUO_W-1:0] quo;
    logic [gars_pkg::NUM_W-1:0] div_num;
    gars_pkg::mac_ctrl_t mac_ctrl;

    function automatic logic signed [17:0] sat_sign(input logic neg, input logic [41:0] q);
        logic [41:0] cap;
        logic [17:0] c;
        cap = neg ? 42'd131072 : 42'd131071;
        c = (q > cap) ? cap[17:0] : q[17:0];
        return neg ? -$signed(c) : $signed(c);
    endfunction

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    assign in_stall  = state_reg != gars_pkg::ST_IDLE;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign dt_ok = seen_reg && step_us >= gars_pkg::DT_MIN_US
                   && step_us <= gars_pkg::DT_MAX_US;
    assign ff_on = op_reg == gars_pkg::OP_RATE && yaw_reg != gars_pkg::YAW_NAN;

    // operand selection
    always_comb
    begin
        col_a = step_reg[0] ? gars_pkg::axis_q(axis_reg) : gars_pkg::axis_p(axis_reg);
        col_b = step_reg[0] ? gars_pkg::axis_p(axis_reg) : gars_pkg::axis_q(axis_reg);
        ib = {1'b0, step_reg[2:1], 1'b0} + {2'b0, step_reg[2:1]} + {2'b0, col_b};
        ia = {1'b0, step_reg[2:1], 1'b0} + {2'b0, step_reg[2:1]} + {2'b0, col_a};
        if (state_reg == gars_pkg::ST_SCALE)
        begin
            ia = 4'd6 + {2'b0, axis_reg};
        end
        w_cl = (yaw_weight_reg > gars_pkg::W_ONE) ? gars_pkg::W_ONE : yaw_weight_reg;
        case (op_reg)
            gars_pkg::OP_SET:  k_sel = gars_pkg::K_USEC;
            gars_pkg::OP_RATE: k_sel = (axis_reg == 2'd2)
                                       ? $signed({6'b0, w_cl, 2'b0} + {8'b0, w_cl})
                                       : gars_pkg::K_RATE;
            default:           k_sel = gars_pkg::K_FIVE;
        endcase
        x_val = (op_reg == gars_pkg::OP_SET && s_reg[36]) ? -s_reg : s_reg;
        if (state_reg == gars_pkg::ST_VEE)
        begin
            mul_a = 20'(m_reg[ia[3:0]]);
            mul_b = 21'(b_reg[ib[3:0]]);
        end
        else if (step_reg == 3'd0)
        begin
            mul_a = $signed({3'b0, x_val[16:0]});
            mul_b = k_sel;
        end
        else if (step_reg == 3'd1)
        begin
            mul_a = x_val[36:17];
            mul_b = k_sel;
        end
        else
        begin
            mul_a = 20'(m_reg[ia[3:0]]);
            mul_b = 21'(yaw_reg);
        end
    end

    // results of ops 1 and 2 from the accumulator; divider numerator and result for op 0
    always_comb
    begin
        sum2 = acc + ($signed(AW'(dbr_reg[axis_reg])) <<< 16);
        case (axis_reg)
            2'd0:    lim = roll_lim_reg;
            2'd1:    lim = pitch_lim_reg;
            default: lim = yaw_lim_reg;
        endcase
        if (op_reg == gars_pkg::OP_RATE)
        begin
            mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
            rnd = mag + (AW'(1) << 27);
            q1  = rnd[57:28];
            fin_res = (q1 > {14'b0, lim}) ? 18'($signed({2'b0, lim}))
                                          : 18'($signed({1'b0, q1[16:0]}));
            if (acc[AW-1])
            begin
                fin_res = -fin_res;
            end
        end
        else
        begin
            mag = sum2[AW-1] ? AW'(-sum2) : AW'(sum2);
            rnd = mag + (AW'(1) << 15);
            q1  = rnd[45:16];
            fin_res = sat_sign(sum2[AW-1], rnd[57:16]);
        end
        div_res = sat_sign(s_reg[36], {10'b0, quo});
        div_num = acc[gars_pkg::NUM_W-1:0] + {20'b0, dt_reg, 19'b0} - {20'b0, dt_reg, 19'b0}
                  + {19'b0, dt_reg, 20'b0} - {19'b0, dt_reg, 20'b0}
                  + {23'b0, dt_reg, 16'b0};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        axis_next  = axis_reg;
        mac_ctrl   = '0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            gars_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    step_next = '0;
                    axis_next = '0;
                    if ((op == gars_pkg::OP_SET && dt_ok) || op == gars_pkg::OP_RATE
                        || op == gars_pkg::OP_ACCEL)
                    begin
                        state_next = gars_pkg::ST_VEE;
                    end
                    else
                    begin
                        state_next = gars_pkg::ST_DONE;
                    end
                end
            end
            gars_pkg::ST_VEE:
            begin
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = step_reg == 3'd0;
                mac_ctrl.neg = step_reg[0];
                mac_ctrl.sh  = gars_pkg::SH_NONE;
                if (step_reg == 3'd5)
                begin
                    step_next  = '0;
                    state_next = gars_pkg::ST_VWAIT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            gars_pkg::ST_VWAIT:
            begin
                state_next = gars_pkg::ST_LATCH;
            end
            gars_pkg::ST_LATCH:
            begin
                state_next = gars_pkg::ST_SCALE;
            end
            gars_pkg::ST_SCALE:
            begin
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = step_reg == 3'd0;
                case (step_reg)
                    3'd0:    mac_ctrl.sh = gars_pkg::SH_NONE;
                    3'd1:    mac_ctrl.sh = gars_pkg::SH_HI;
                    default: mac_ctrl.sh = gars_pkg::SH_FF;
                endcase
                if (step_reg == 3'd2 || (step_reg == 3'd1 && !ff_on))
                begin
                    step_next  = '0;
                    state_next = gars_pkg::ST_SWAIT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            gars_pkg::ST_SWAIT:
            begin
                state_next = gars_pkg::ST_FIN;
            end
            gars_pkg::ST_FIN:
            begin
                if (op_reg == gars_pkg::OP_SET)
                begin
                    div_start  = 1'b1;
                    state_next = gars_pkg::ST_DIV;
                end
                else if (axis_reg == 2'd2)
                begin
                    state_next = gars_pkg::ST_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = gars_pkg::ST_VEE;
                end
            end
            gars_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = gars_pkg::ST_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = gars_pkg::ST_VEE;
                    end
                end
            end
            gars_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = gars_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gars_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gars_pkg::ST_IDLE;
            step_reg  <= '0;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            axis_reg  <= axis_next;
        end
    end

    // configuration and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_weight_reg <= gars_pkg::W_ONE;
            roll_lim_reg   <= 16'd15729;
            pitch_lim_reg  <= 16'd15729;
            yaw_lim_reg    <= 16'd6400;
            for (int i = 0; i < 9; i++)
            begin
                d_reg[i] <= (i % 4 == 0) ? gars_pkg::ONE_Q14 : 16'sd0;
            end
            for (int i = 0; i < 3; i++)
            begin
                dbr_reg[i] <= '0;
            end
            seen_reg      <= 1'b0;
            yaw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    gars_pkg::REG_YAW_WEIGHT: yaw_weight_reg <= cfg_data[12:0];
                    gars_pkg::REG_ROLL_LIM:   roll_lim_reg   <= cfg_data;
                    gars_pkg::REG_PITCH_LIM:  pitch_lim_reg  <= cfg_data;
                    gars_pkg::REG_YAW_LIM:    yaw_lim_reg    <= cfg_data;
                    default:                  ;
                endcase
            end
            if (accept && op == gars_pkg::OP_SET)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    d_reg[i] <= m_in[i];
                end
                seen_reg <= 1'b1;
                yaw_reg  <= yaw_speed;
                if (!dt_ok)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        dbr_reg[i] <= '0;
                    end
                end
            end
            if (state_reg == gars_pkg::ST_DIV && div_done)
            begin
                dbr_reg[axis_reg] <= div_res;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op;
            dt_reg <= step_us[16:0];
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= m_in[i];
                b_reg[i] <= (op == gars_pkg::OP_SET) ? 17'(m_in[i]) - 17'(d_reg[i])
                                                     : 17'(d_reg[i]);
            end
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= '0;
            end
        end
        if (state_reg == gars_pkg::ST_LATCH)
        begin
            s_reg <= acc[36:0];
        end
        if (state_reg == gars_pkg::ST_FIN && op_reg != gars_pkg::OP_SET)
        begin
            res_reg[axis_reg] <= fin_res;
        end
        if (state_reg == gars_pkg::ST_DIV && div_done)
        begin
            res_reg[axis_reg] <= div_res;
        end
        if (load_out)
        begin
            out_x_reg <= res_reg[0];
            out_y_reg <= res_reg[1];
            out_z_reg <= res_reg[2];
        end
    end

    gars_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mul_a),
        .b     (mul_b),
        .acc   (acc)
    );

    gars_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({dt_reg, 17'b0}),
        .done  (div_done),
        .quo   (quo)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;

endmodule

FILE: design/gars_checker.sv
// Port-level checks for geometric_attitude_rate_setpoint, bound to the top.
// Depends only on the top level's ports.
module gars_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [17:0] out_x,
    input logic signed [17:0] out_y,
    input logic signed [17:0] out_z
);

    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block took no time over an item");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result appeared in the cycle after an item");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_x)
                                      && $stable(out_y) && $stable(out_z)))
        else $error("stalled result changed");

endmodule

bind geometric_attitude_rate_setpoint gars_checker u_gars_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
);
